>>> rtl/core/lrukv_pkg.sv
package lrukv_pkg;

   localparam int LRUKV_ENTRIES = 16;

   localparam logic [4:0]  CAP_RESET  = 5'd16;
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_payload_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctrl_type;

endpackage

>>> rtl/core/lrukv_data_ram.sv
module lrukv_data_ram #(
   parameter int ENTRIES = lrukv_pkg::LRUKV_ENTRIES
) (
   input  logic                       clock,
   input  lrukv_pkg::ram_ctrl_type    ctrl,
   input  logic [$clog2(ENTRIES)-1:0] addr,
   input  logic [31:0]                wr_data,
   output logic [31:0]                rd_data
);
   import lrukv_pkg::*;

   logic [31:0] mem_ff [ENTRIES];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lrukv_tag_array.sv
module lrukv_tag_array #(
   parameter int ENTRIES = lrukv_pkg::LRUKV_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  lrukv_pkg::op_type          opcode,
   input  logic [31:0]                key,
   input  logic [4:0]                 capacity,
   output logic                       hit,
   output logic [$clog2(ENTRIES)-1:0] slot
);
   import lrukv_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [31:0]        key_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];
   logic [CW-1:0]      count_ff, count_in;

   logic [ENTRIES-1:0] match, victim, free_first, sel;
   logic [IW-1:0]      slot_idx, old_rank;
   logic [7:0]         cap_eff;
   logic               any_free, full, alloc_free, is_put, touch, write_key, was_valid;

   always_comb begin
      any_free = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]      = valid_ff[i] && (key_ff[i] == key);
         victim[i]     = valid_ff[i] && (CW'(rank_ff[i]) == count_ff - CW'(1));
         free_first[i] = !valid_ff[i] && !any_free;
         any_free      = any_free | !valid_ff[i];
      end
   end

   always_comb begin
      hit        = |match;
      is_put     = (opcode == OP_PUT);
      cap_eff    = (capacity == 5'd0) ? 8'd1 : 8'(capacity);
      full       = (8'(count_ff) >= cap_eff) || (count_ff == CW'(ENTRIES));
      alloc_free = !full && any_free;
      touch      = en && (hit || is_put);
      write_key  = en && is_put && !hit;
      // hit entry, else lowest free entry, else the least recent one
      sel        = hit ? match : (alloc_free ? free_first : victim);
      was_valid  = hit || !alloc_free;
      slot_idx   = '0;
      old_rank   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            slot_idx = slot_idx | IW'(i);
            old_rank = old_rank | rank_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i] | (write_key && sel[i]);
         rank_in[i]  = rank_ff[i];
         if (touch) begin
            if (sel[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (!was_valid || rank_ff[i] < old_rank)) begin
               // age every entry younger than the one moved to the front
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end
      end
      count_in = count_ff + CW'(write_key && alloc_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (write_key && sel[i]) begin
            key_ff[i] <= key;
         end
      end
   end

   assign slot = slot_idx;

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key matches more than one entry");

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(valid_ff)))
      else $error("occupancy count differs from valid entries");

   a_victim_unique: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> $onehot(victim))
      else $error("least recent entry not unique");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("occupancy above entry count");

endmodule

>>> rtl/core/lru_key_value_cache_unit.sv
// A get is registered in stage_valid_ff and stage_req_ff for the lookup; its result is then
// registered in strobe_ff, found_ff and the data RAM read register, which drive rsp_strobe and rsp_payload.
// Throughput: one item per cycle while busy is low, set by the key compare and rank update.
// A put gives no result; the receiver cannot stall, so busy is high only during reset.
// Reset clears the valid bits, recency ranks, occupancy count and sets capacity to 16.
// Stored keys and values are not cleared; only valid entries are ever read.
module lru_key_value_cache_unit #(
   parameter int ENTRIES = lrukv_pkg::LRUKV_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lrukv_pkg::req_payload_type req_payload,
   output logic                       rsp_strobe,
   output lrukv_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [4:0]                 csr_write_data
);
   import lrukv_pkg::*;

   localparam int IW = $clog2(ENTRIES);

   logic            stage_valid_ff;
   req_payload_type stage_req_ff;
   logic [4:0]      capacity_ff;
   logic            strobe_ff, found_ff;

   logic            hit;
   logic [IW-1:0]   slot;
   ram_ctrl_type    ram_ctrl;
   logic [31:0]     ram_rd_data;
   logic            is_get;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         capacity_ff    <= CAP_RESET;
         strobe_ff      <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         stage_valid_ff <= start;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         strobe_ff <= stage_valid_ff && is_get;
         found_ff  <= stage_valid_ff && is_get && hit;
      end
   end

   // hold the accepted request for the lookup cycle
   always_ff @(posedge clock) begin
      if (start) begin
         stage_req_ff <= req_payload;
      end
   end

   assign is_get = (stage_req_ff.opcode == OP_GET);

   lrukv_tag_array #(
      .ENTRIES (ENTRIES)
   ) u_tag_array (
      .clock    (clock),
      .reset    (reset),
      .en       (stage_valid_ff),
      .opcode   (stage_req_ff.opcode),
      .key      (stage_req_ff.key),
      .capacity (capacity_ff),
      .hit      (hit),
      .slot     (slot)
   );

   always_comb begin
      ram_ctrl.wr_en = stage_valid_ff && !is_get;
      ram_ctrl.rd_en = stage_valid_ff && is_get && hit;
   end

   lrukv_data_ram #(
      .ENTRIES (ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .addr    (slot),
      .wr_data (stage_req_ff.value),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe             = strobe_ff;
   assign rsp_payload.found      = found_ff;
   assign rsp_payload.read_value = found_ff ? ram_rd_data : MISS_VALUE;

   a_found_has_strobe: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> strobe_ff)
      else $error("found without result transfer");

   a_strobe_from_get: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(stage_valid_ff))
      else $error("result transfer without a request in flight");

   a_read_on_hit: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> $past(ram_ctrl.rd_en))
      else $error("hit reported without value read");

endmodule
